@@ rtl/fit_policy_block_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_defines
// assertion macros for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FPBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// types, codes and defaults of the fit policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

    // default sizing
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    // fit policy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 5;
    localparam logic [0:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [0:0] CFG_BLOCK_COUNT = 1'd1;

    // configuration reset values
    localparam logic [1:0] FIT_MODE_RST    = FIT_FIRST;
    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    // command transfer
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  block_index;
        logic [15:0] size;
    } t_in;

    // result transfer
    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining;
    } t_out;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RESTORE,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

@@ rtl/fpba_ram.sv @@
// ----------------------------------------------------------------------------
// fpba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fit_policy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// load: S_LOAD, then the S_DONE result strobe; unused codes go to S_DONE directly
// allocate: S_SEARCH, then S_UPDATE only when granted, then S_DONE
//   (one ram read and one compare per searched block); restore: whole table
// busy stays high until the result strobe; results cannot be held off
// synchronous active-low reset returns to idle with fit_mode 0, block_count 16
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_defines.svh"

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_in,
    // result channel
    output logic                  o_out_valid,
    output t_out                  o_out,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // configuration registers
    logic [1:0] r_fit_mode;
    logic [4:0] r_block_count;

    // sequencer and datapath registers
    t_state                r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [3:0]            r_idx, n_idx;
    logic [SIZE_BITS-1:0]  r_size, n_size;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_limit, n_limit;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pend_addr, n_pend_addr;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_pick, n_pick;
    logic [SIZE_BITS-1:0]  r_best, n_best;
    t_out                  r_out, n_out;

    // ram ports
    logic                  free_we, orig_we;
    logic [IDX_W-1:0]      free_waddr, orig_waddr;
    logic [SIZE_BITS-1:0]  free_wdata, orig_wdata;
    logic [SIZE_BITS-1:0]  free_rdata, orig_rdata;

    // shared compare and subtract unit
    logic                  accept;
    logic                  issue;
    logic                  fits;
    logic                  better;
    logic                  take;
    logic                  load_ok;
    logic [SIZE_BITS-1:0]  diff;
    logic [CNT_W-1:0]      sat_count;

    assign accept  = start && !busy;
    assign issue   = (r_state == S_RESTORE || r_state == S_SEARCH) && (r_cnt < r_limit);
    assign fits    = free_rdata >= r_size;
    assign better  = (r_fit_mode == FIT_BEST) ? (free_rdata < r_best) : (free_rdata > r_best);
    assign take    = (r_state == S_SEARCH) && r_pend && fits &&
                     (!r_found || (r_fit_mode != FIT_FIRST && better));
    assign diff    = r_best - r_size;
    assign load_ok = 32'(r_idx) < 32'(MAX_BLOCKS);

    // block count saturated to the table depth
    always_comb begin
        if (32'(r_block_count) > 32'(MAX_BLOCKS)) begin
            sat_count = CNT_W'(MAX_BLOCKS);
        end else begin
            sat_count = CNT_W'(r_block_count);
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_MODE_RST;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.command)
                        CMD_LOAD:    n_state = S_LOAD;
                        CMD_RESTORE: n_state = S_RESTORE;
                        CMD_ALLOC: begin
                            if (r_fit_mode inside {FIT_FIRST, FIT_BEST, FIT_WORST}) begin
                                n_state = S_SEARCH;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD:    n_state = S_DONE;
            S_RESTORE: begin
                if (!issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (!issue && !r_pend) begin
                    n_state = r_found ? S_UPDATE : S_DONE;
                end
            end
            S_UPDATE:  n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and ram controls
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_out_valid = (r_state == S_DONE);
        free_we     = 1'b0;
        free_waddr  = r_pend_addr;
        free_wdata  = orig_rdata;
        orig_we     = 1'b0;
        orig_waddr  = IDX_W'(r_idx);
        orig_wdata  = r_size;
        case (r_state)
            S_LOAD: begin
                free_we    = load_ok;
                orig_we    = load_ok;
                free_waddr = IDX_W'(r_idx);
                free_wdata = r_size;
            end
            S_RESTORE: begin
                free_we = r_pend;
            end
            S_UPDATE: begin
                free_we    = 1'b1;
                free_waddr = r_pick;
                free_wdata = diff;
            end
            default: ;
        endcase
    end

    assign o_out = r_out;

    // datapath next values
    always_comb begin
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_size      = r_size;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_found     = r_found;
        n_pick      = r_pick;
        n_best      = r_best;
        n_out       = r_out;
        if (accept) begin
            n_cmd   = i_in.command;
            n_idx   = i_in.block_index;
            n_size  = SIZE_BITS'(i_in.size);
            n_cnt   = '0;
            n_found = 1'b0;
            n_pick  = '0;
            n_best  = '0;
            n_out   = '0;
            n_limit = (i_in.command == CMD_RESTORE) ? CNT_W'(MAX_BLOCKS) : sat_count;
        end
        // one table read per cycle during a sweep
        if (issue) begin
            n_pend      = 1'b1;
            n_pend_addr = IDX_W'(r_cnt);
            n_cnt       = r_cnt + 1'b1;
        end
        // fit policy compare on the returned entry
        if (take) begin
            n_found = 1'b1;
            n_pick  = r_pend_addr;
            n_best  = free_rdata;
        end
        if (r_state == S_UPDATE) begin
            n_out.granted      = 1'b1;
            n_out.chosen_block = 4'(r_pick);
            n_out.remaining    = 16'(diff);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_size      <= n_size;
        r_cnt       <= n_cnt;
        r_limit     <= n_limit;
        r_pend_addr <= n_pend_addr;
        r_found     <= n_found;
        r_pick      <= n_pick;
        r_best      <= n_best;
        r_out       <= n_out;
    end

    // free size table
    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (IDX_W'(r_cnt)),
        .o_rdata (free_rdata)
    );

    // original size table
    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_orig_ram (
        .i_clk   (i_clk),
        .i_we    (orig_we),
        .i_waddr (orig_waddr),
        .i_wdata (orig_wdata),
        .i_raddr (IDX_W'(r_cnt)),
        .o_rdata (orig_rdata)
    );

    // checks
    `FPBA_ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `FPBA_ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, o_out_valid, !busy)
    `FPBA_ASSERT_SAME(a_refusal_is_zero, i_clk, i_rst_n,
        o_out_valid && !o_out.granted,
        o_out.chosen_block == 4'd0 && o_out.remaining == 16'd0)
    `FPBA_ASSERT_SAME(a_grant_from_alloc, i_clk, i_rst_n,
        o_out_valid && o_out.granted, r_cmd == CMD_ALLOC)

endmodule

@@ sim/fit_policy_block_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_checker
// watches the command, result and register channels of the allocator, keeps
// its own copy of the block table and the fit policy, predicts each grant
// and compares every result transfer field by field with the oldest one
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_checker
    import fpba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in                   i_cmd,
    // result channel
    input  logic                  i_res_valid,
    input  t_out                  i_res,
    // register channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status towards the stimulus side
    output int                    o_pending,
    output int                    o_fail_count
);

    // shadow of the block table and the registers
    logic [15:0] free_left  [MAX_BLOCKS_DEF];
    logic [15:0] base_size  [MAX_BLOCKS_DEF];
    logic [1:0]  fit_mode_q;
    logic [4:0]  block_count_q;

    t_out predicted_grants [$];
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // applies one command to the shadow table and gives the result it causes
    function automatic t_out apply_command(input t_in cmd);
        t_out res;
        int   span;
        int   pick;
        bit   found;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        case (cmd.command)
            CMD_LOAD: begin
                base_size[cmd.block_index] = cmd.size;
                free_left[cmd.block_index] = cmd.size;
            end
            CMD_RESTORE: begin
                for (int k = 0; k < MAX_BLOCKS_DEF; k++) free_left[k] = base_size[k];
            end
            CMD_ALLOC: begin
                if (fit_mode_q == FIT_FIRST || fit_mode_q == FIT_BEST ||
                    fit_mode_q == FIT_WORST) begin
                    // counts above the table size search the whole table
                    span = (block_count_q > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF
                                                            : int'(block_count_q);
                    for (int k = 0; k < span; k++) begin
                        if (free_left[k] >= cmd.size) begin
                            // first fit keeps the first hit, ties keep the lower index
                            if (!found) begin
                                found = 1'b1;
                                pick  = k;
                            end else if (fit_mode_q == FIT_BEST &&
                                         free_left[k] < free_left[pick]) begin
                                pick = k;
                            end else if (fit_mode_q == FIT_WORST &&
                                         free_left[k] > free_left[pick]) begin
                                pick = k;
                            end
                        end
                    end
                    if (found) begin
                        free_left[pick]  = free_left[pick] - cmd.size;
                        res.granted      = 1'b1;
                        res.chosen_block = pick[3:0];
                        res.remaining    = free_left[pick];
                    end
                end
            end
            default: begin
                // unused command code leaves the table alone
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BLOCKS_DEF; k++) begin
                free_left[k] = '0;
                base_size[k] = '0;
            end
            fit_mode_q    = FIT_MODE_RST;
            block_count_q = BLOCK_COUNT_RST;
            predicted_grants.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_res_valid) begin
                if (predicted_grants.size() == 0) begin
                    report_mismatch("result with no command pending", 16'd1, 16'd0);
                end else begin
                    want = predicted_grants.pop_front();
                    if (i_res.granted !== want.granted)
                        report_mismatch("granted", 16'(i_res.granted), 16'(want.granted));
                    if (i_res.chosen_block !== want.chosen_block)
                        report_mismatch("chosen_block", 16'(i_res.chosen_block),
                                        16'(want.chosen_block));
                    if (i_res.remaining !== want.remaining)
                        report_mismatch("remaining", i_res.remaining, want.remaining);
                end
            end
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIT_MODE:    fit_mode_q    = i_cfg_data[1:0];
                    CFG_BLOCK_COUNT: block_count_q = i_cfg_data;
                    default: ;
                endcase
            end
            // command transfer
            if (i_start && !i_busy) predicted_grants.push_back(apply_command(i_cmd));
        end
        o_pending <= predicted_grants.size();
    end

endmodule

@@ sim/fit_policy_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// fills the block table, runs a directed pass over extremes, ties and every
// command and fit policy, then random phases under changing register
// settings with random gaps between commands; the checker predicts results
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [1:0] FIT_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = MAX_BLOCKS_DEF + 4;
    localparam int         RANDOM_PHASES = 8;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    t_in                   cmd_word  = '0;
    logic                  res_valid;
    t_out                  res_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    pending;
    int                    fail_count;
    int                    cycle_count = 0;
    int                    quiet_left  = 0;
    logic [15:0]           seed_sizes [MAX_BLOCKS_DEF];

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fit_policy_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (cmd_word),
        .o_out_valid (res_valid),
        .o_out       (res_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fit_policy_block_allocator_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd_word),
        .i_res_valid  (res_valid),
        .i_res        (res_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // gap before the next command: mostly short, a few long, some bursts
    function int next_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sizes biased towards extremes and repeated values so that ties occur
    function logic [15:0] draw_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        if (r < 40) return 16'($urandom_range(0, 15) * 64);
        if (r < 70) return 16'($urandom_range(0, 4095));
        return 16'($urandom_range(0, 65535));
    endfunction

    // one command transfer, then a random gap
    task automatic send_cmd(input logic [1:0] op, input logic [3:0] idx,
                            input logic [15:0] sz);
        int gap;
        start    <= 1'b1;
        cmd_word <= '{command: op, block_index: idx, size: sz};
        do @(posedge i_clk); while (busy);
        gap = next_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int         phase_items;
        int         r;
        logic [1:0] mode;
        logic [4:0] count;
        seed_sizes = '{16'hFFFF, 16'h0000, 16'd500, 16'd300, 16'd300, 16'hFFFF,
                       16'd1200, 16'd40, 16'd7, 16'd4096, 16'd2000, 16'd300,
                       16'd65000, 16'd1, 16'd999, 16'hAAAA};

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table so that no search or restore reads an empty entry
        for (int k = 0; k < MAX_BLOCKS_DEF; k++)
            send_cmd(CMD_LOAD, 4'(k), seed_sizes[k]);

        // first fit: zero request, full size requests, refusal, unused code, restore
        send_cmd(CMD_ALLOC, 4'hF, 16'h0000);
        send_cmd(CMD_ALLOC, 4'h0, 16'hFFFF);
        send_cmd(CMD_ALLOC, 4'h5, 16'hFFFF);
        send_cmd(CMD_ALLOC, 4'hA, 16'hFFFF);
        send_cmd(CMD_UNUSED, 4'hF, 16'hFFFF);
        send_cmd(CMD_RESTORE, 4'h0, 16'h0000);

        // best fit with a three-way tie
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
        send_cmd(CMD_ALLOC, 4'h0, 16'd250);

        // worst fit with a tie at full size
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        send_cmd(CMD_ALLOC, 4'h0, 16'd1);

        // unused fit mode refuses
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_UNUSED));
        send_cmd(CMD_ALLOC, 4'h0, 16'h0000);

        // empty search range refuses, oversized count searches the whole table
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
        write_reg(CFG_BLOCK_COUNT, 5'd0);
        send_cmd(CMD_ALLOC, 4'h0, 16'h0000);
        wait_idle();
        write_reg(CFG_BLOCK_COUNT, 5'd31);
        send_cmd(CMD_ALLOC, 4'h0, 16'd65000);

        // random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p == 6) ? FIT_UNUSED : 2'(p % 3);
            case (p)
                0, 3, 6: count = 5'd16;
                1:       count = 5'd1;
                2:       count = 5'($urandom_range(2, 15));
                4:       count = 5'($urandom_range(17, 31));
                5:       count = 5'd0;
                default: count = 5'($urandom_range(1, 16));
            endcase
            phase_items = (p == 5 || p == 6) ? 60 : 340;
            wait_idle();
            write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode));
            write_reg(CFG_BLOCK_COUNT, count);
            repeat (phase_items) begin
                r = $urandom_range(0, 99);
                if (r < 62)
                    send_cmd(CMD_ALLOC, 4'($urandom), draw_size());
                else if (r < 84)
                    send_cmd(CMD_LOAD, 4'($urandom), draw_size());
                else if (r < 94)
                    send_cmd(CMD_RESTORE, 4'($urandom), 16'($urandom));
                else
                    send_cmd(CMD_UNUSED, 4'($urandom), 16'($urandom));
            end
        end

        // drain and let the block settle
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
